// ===== rtl/tti_pkg.sv =====
// Shared types and constants for the track table interpolator.
package tti_pkg;

   localparam int IdW     = 30;
   localparam int LatW    = 27;
   localparam int LonW    = 28;
   localparam int SpdW    = 10;
   localparam int CogW    = 12;
   localparam int TimeW   = 47;
   localparam int OLatW   = 28;
   localparam int OLonW   = 29;
   localparam int OSpdW   = 12;
   localparam int CoordW  = 28;

   localparam logic [11:0] CogFull = 12'd3600;
   localparam logic [11:0] CogHalf = 12'd1800;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic CSR_INVALID_ID    = 1'b0;
   localparam logic CSR_INVALID_COORD = 1'b1;

   typedef struct packed {
      logic signed [LatW-1:0] lat;
      logic signed [LonW-1:0] lon;
      logic [SpdW-1:0]        spd;
      logic [CogW-1:0]        cog;
      logic [TimeW-1:0]       t;
   } rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_FETCH,
      ST_WRITE,
      ST_QREAD,
      ST_QCHECK,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear_idx;
      logic inc_idx;
      logic load_req;
      logic scan_step;
      logic fetch_tgt;
      logic write_slot;
      logic read_slot;
      logic div_start;
      logic div_step;
      logic mul_load;
      logic sum_load;
      logic emit;
      logic emit_last;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic idx_end;
      logic slot_hit;
      logic slot_used;
      logic blend_ok;
      logic div_done;
      logic any_later;
      logic req_ok;
   } stat_type;

endpackage

// ===== rtl/tti_datapath.sv =====
// Datapath of the track table interpolator: table storage, alpha divider and blend.
module tti_datapath
   import tti_pkg::*;
#(
   parameter int TRACKS          = 32,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     req_decode_ok,
   input  logic [IdW-1:0]           req_vessel_id,
   input  logic signed [LatW-1:0]   req_latitude,
   input  logic signed [LonW-1:0]   req_longitude,
   input  logic [SpdW-1:0]          req_speed,
   input  logic [CogW-1:0]          req_course,
   input  logic [TimeW-1:0]         req_time_ms,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [31:0]              csr_data,
   output logic                     rsp_strobe,
   output logic [IdW-1:0]           rsp_out_vessel_id,
   output logic signed [OLatW-1:0]  rsp_out_latitude,
   output logic signed [OLonW-1:0]  rsp_out_longitude,
   output logic signed [OSpdW-1:0]  rsp_out_speed,
   output logic [CogW-1:0]          rsp_out_course,
   output logic                     rsp_last
);

   localparam int IdxW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int CntW = $clog2(TRACKS + 1);
   localparam int AW   = ALPHA_FRAC_BITS + 2;
   localparam int FW   = ALPHA_FRAC_BITS;
   localparam int DW   = TimeW + 2;
   localparam int SumW = 32 + AW + 2;

   // Configuration registers.
   logic [IdW-1:0]           inv_id_ff;
   logic signed [CoordW-1:0] inv_coord_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_id_ff    <= '0;
         inv_coord_ff <= 28'sd54600000;
      end else if (csr_we) begin
         if (csr_index == CSR_INVALID_ID) inv_id_ff <= csr_data[IdW-1:0];
         else inv_coord_ff <= csr_data[CoordW-1:0];
      end
   end

   // Captured request.
   logic [IdW-1:0] id_ff;
   rec_type        rec_ff;
   logic           ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         id_ff      <= req_vessel_id;
         rec_ff.lat <= req_latitude;
         rec_ff.lon <= req_longitude;
         rec_ff.spd <= req_speed;
         rec_ff.cog <= req_course;
         rec_ff.t   <= req_time_ms;
         ok_ff      <= req_decode_ok && (req_vessel_id != inv_id_ff)
                       && (CoordW'(req_latitude) != inv_coord_ff)
                       && (req_longitude != inv_coord_ff);
      end
   end

   // Slot index counter.
   logic [CntW-1:0] idx_ff;
   logic [IdxW-1:0] idx;
   assign idx = idx_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_idx) idx_ff <= '0;
      else if (cmd.inc_idx) idx_ff <= idx_ff + 1'b1;
   end

   // Per-slot flags in flip-flops; records in memories.
   logic [TRACKS-1:0] used_ff, pvalid_ff;
   logic [IdW-1:0]    ident_mem [TRACKS];
   rec_type           cur_mem   [TRACKS];
   rec_type           prev_mem  [TRACKS];

   // Scan result: first hit, lowest free slot.
   logic            found_ff, hit_ff, free_ff;
   logic [IdxW-1:0] tgt_ff;
   logic [IdW-1:0]  ident_rd_ff;

   always_ff @(posedge clock) begin
      ident_rd_ff <= ident_mem[idx];
   end

   // ident_rd_ff is read through a register from idx; the scan compares the slot held in sidx_ff.
   logic [IdxW-1:0] sidx_ff;
   logic            sval_ff;
   always_ff @(posedge clock) begin
      sidx_ff <= idx;
      sval_ff <= cmd.scan_step && (idx_ff < CntW'(TRACKS));
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_req) begin
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else if (sval_ff && !found_ff) begin
         if (used_ff[sidx_ff] && ident_rd_ff == id_ff) begin
            found_ff <= 1'b1;
            hit_ff   <= 1'b1;
            tgt_ff   <= sidx_ff;
         end else if (!used_ff[sidx_ff] && !free_ff) begin
            free_ff <= 1'b1;
            tgt_ff  <= sidx_ff;
         end
      end
   end

   // Table write.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         pvalid_ff <= '0;
      end else if (cmd.write_slot && ok_ff && (hit_ff || free_ff)) begin
         used_ff[tgt_ff]   <= 1'b1;
         pvalid_ff[tgt_ff] <= hit_ff;
      end
   end

   logic do_wr;
   assign do_wr = cmd.write_slot && ok_ff && (hit_ff || free_ff);

   // The target record is fetched in the cycle before the write.
   rec_type cur_rd_ff, prev_rd_ff;
   logic [IdxW-1:0] raddr;
   assign raddr = (cmd.fetch_tgt || cmd.write_slot) ? tgt_ff : idx;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         ident_mem[tgt_ff] <= id_ff;
         cur_mem[tgt_ff]   <= rec_ff;
         if (hit_ff) prev_mem[tgt_ff] <= cur_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_rd_ff  <= cur_mem[raddr];
      prev_rd_ff <= prev_mem[raddr];
   end

   // Query operands.
   rec_type        c_ff, p_ff;
   logic [IdW-1:0] oid_ff;
   logic           pv_ff;
   logic signed [DW-1:0] gap_ff, num_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_slot) begin
         c_ff   <= cur_rd_ff;
         p_ff   <= prev_rd_ff;
         oid_ff <= ident_rd_ff;
         pv_ff  <= pvalid_ff[idx];
         gap_ff <= DW'(cur_rd_ff.t) - DW'(prev_rd_ff.t);
         num_ff <= DW'(rec_ff.t) - DW'(prev_rd_ff.t);
      end
   end

   // Restoring divider, one quotient bit per cycle.
   logic [DW-1:0]     rem_ff;
   logic [AW-1:0]     alpha_ff;
   logic [$clog2(FW+1)-1:0] cnt_ff;
   logic              ddone_ff;
   logic [DW-1:0]     rsh;

   assign rsh = {rem_ff[DW-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         ddone_ff <= 1'b0;
         cnt_ff   <= '0;
         if (num_ff <= 0) begin
            alpha_ff <= '0;
            ddone_ff <= 1'b1;
         end else if (num_ff >= (gap_ff <<< 1)) begin
            alpha_ff <= AW'(2) << FW;
            ddone_ff <= 1'b1;
         end else if (num_ff >= gap_ff) begin
            alpha_ff <= AW'(1);
            rem_ff   <= num_ff - gap_ff;
         end else begin
            alpha_ff <= '0;
            rem_ff   <= num_ff;
         end
      end else if (cmd.div_step && !ddone_ff) begin
         if (rsh >= gap_ff) begin
            rem_ff   <= rsh - gap_ff;
            alpha_ff <= {alpha_ff[AW-2:0], 1'b1};
         end else begin
            rem_ff   <= rsh;
            alpha_ff <= {alpha_ff[AW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(FW+1))'(FW - 1)) ddone_ff <= 1'b1;
      end
   end

   // Differences and products, one multiplier per field.
   logic signed [29:0] dlat, dlon;
   logic signed [12:0] dspd, dcog_raw, dcog;
   always_comb begin
      dlat     = 30'(c_ff.lat) - 30'(p_ff.lat);
      dlon     = 30'(c_ff.lon) - 30'(p_ff.lon);
      dspd     = $signed({3'b0, c_ff.spd}) - $signed({3'b0, p_ff.spd});
      dcog_raw = $signed({1'b0, c_ff.cog}) - $signed({1'b0, p_ff.cog});
      dcog     = dcog_raw;
      if (dcog_raw > $signed({1'b0, CogHalf})) dcog = dcog_raw - $signed({1'b0, CogFull});
      else if (dcog_raw < -$signed({1'b0, CogHalf}))
         dcog = dcog_raw + $signed({1'b0, CogFull});
   end

   logic signed [SumW-1:0] plat_ff, plon_ff, pspd_ff, pcog_ff;
   logic signed [AW:0]     sa;
   assign sa = $signed({1'b0, alpha_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         plat_ff <= SumW'(sa * dlat);
         plon_ff <= SumW'(sa * dlon);
         pspd_ff <= SumW'(sa * dspd);
         pcog_ff <= SumW'(sa * dcog);
      end
   end

   // Add base, shift, saturate.
   function automatic logic signed [SumW-1:0] tdiv(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] a;
      a = (v < 0) ? -v : v;
      a = a >>> FW;
      return (v < 0) ? -a : a;
   endfunction

   logic signed [SumW-1:0] tlat, tlon, tspd, tcog, fcog;
   logic signed [SumW-1:0] slat_ff, slon_ff, sspd_ff, scog_ff;
   always_comb begin
      tlat = (SumW'(p_ff.lat) <<< FW) + plat_ff;
      tlon = (SumW'(p_ff.lon) <<< FW) + plon_ff;
      tspd = (SumW'($signed({1'b0, p_ff.spd})) <<< FW) + pspd_ff;
      tcog = (SumW'($signed({1'b0, p_ff.cog}) + 14'sd3600) <<< FW) + pcog_ff;
      fcog = tcog >>> FW;
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_load) begin
         slat_ff <= tdiv(tlat);
         slon_ff <= tdiv(tlon);
         sspd_ff <= tdiv(tspd);
         scog_ff <= fcog;
      end
   end

   function automatic logic signed [SumW-1:0] satw(input logic signed [SumW-1:0] v,
                                                   input int w);
      logic signed [SumW-1:0] hi, lo;
      hi = (SumW'(1) <<< (w - 1)) - 1;
      lo = -(SumW'(1) <<< (w - 1));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // Course modulo 3600: a stored course may reach 4095, so the value lies
   // in [0, 4*3600).
   logic signed [SumW-1:0] m1, m2;
   logic [CogW-1:0]        cog_mod;
   always_comb begin
      m1 = scog_ff;
      if (m1 >= SumW'(10800)) m2 = m1 - SumW'(10800);
      else if (m1 >= SumW'(7200)) m2 = m1 - SumW'(7200);
      else if (m1 >= SumW'(3600)) m2 = m1 - SumW'(3600);
      else if (m1 < 0) m2 = m1 + SumW'(3600);
      else m2 = m1;
      cog_mod = m2[CogW-1:0];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_vessel_id <= oid_ff;
         rsp_last          <= cmd.emit_last;
         if (stat.blend_ok) begin
            rsp_out_latitude  <= OLatW'(satw(slat_ff, OLatW));
            rsp_out_longitude <= OLonW'(satw(slon_ff, OLonW));
            rsp_out_speed     <= OSpdW'(satw(sspd_ff, OSpdW));
            rsp_out_course    <= cog_mod;
         end else begin
            rsp_out_latitude  <= OLatW'(c_ff.lat);
            rsp_out_longitude <= OLonW'(c_ff.lon);
            rsp_out_speed     <= OSpdW'({2'b0, c_ff.spd});
            rsp_out_course    <= c_ff.cog;
         end
      end
   end

   // Status.
   logic [TRACKS-1:0] later;
   always_comb begin
      later = '0;
      for (int k = 0; k < TRACKS; k++) later[k] = used_ff[k] && (CntW'(k) > idx_ff);
   end

   assign stat.idx_end   = (idx_ff == CntW'(TRACKS - 1)) || (idx_ff >= CntW'(TRACKS));
   assign stat.slot_hit  = found_ff;
   assign stat.slot_used = (idx_ff < CntW'(TRACKS)) && used_ff[idx];
   assign stat.blend_ok  = pv_ff && (gap_ff > 0);
   assign stat.div_done  = ddone_ff;
   assign stat.any_later = |later;
   assign stat.req_ok    = ok_ff;

endmodule

// ===== rtl/tti_control.sv =====
// Sequencing state machine of the track table interpolator.
module tti_control
   import tti_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_command,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req  = 1'b1;
               cmd.clear_idx = 1'b1;
               state_in = (req_command == CMD_QUERY) ? ST_QREAD : ST_SCAN;
            end
         end
         // Walk all slots; each slot is compared in the cycle after its index is presented.
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.inc_idx   = 1'b1;
            if (stat.idx_end) state_in = ST_SCAN_END;
         end
         // The last slot is compared in this cycle.
         ST_SCAN_END: begin
            state_in = ST_FETCH;
         end
         // Read the target record so that it can move to previous.
         ST_FETCH: begin
            cmd.fetch_tgt = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QREAD: begin
            state_in = ST_QCHECK;
         end
         ST_QCHECK: begin
            if (stat.slot_used) begin
               cmd.read_slot = 1'b1;
               state_in = ST_DIV;
            end else if (stat.idx_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in = ST_QREAD;
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.mul_load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = !stat.any_later;
            if (!stat.any_later) begin
               state_in = ST_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in = ST_QREAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/track_table_interpolator.sv =====
// Top level of the track table interpolator.
// A report makes one pass over the slots through the identity memory port,
// finishes the last comparison, fetches the target record, then takes the
// write step. A query visits the slots in turn; for each used slot the serial
// alpha divider retires one quotient bit per cycle, and a slot whose alpha
// clamps to zero or two skips the divider steps. busy falls in the cycle in
// which the last result beat of a query is on the outputs, so the next item
// may be accepted alongside that beat. Results appear on the rsp_ ports for
// one cycle with rsp_strobe high and must be taken then; rsp_last marks the
// final track of a query, and an empty table gives no beats.
module track_table_interpolator
   import tti_pkg::*;
#(
   parameter int TRACKS          = 32,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_command,
   input  logic                     req_decode_ok,
   input  logic [IdW-1:0]           req_vessel_id,
   input  logic signed [LatW-1:0]   req_latitude,
   input  logic signed [LonW-1:0]   req_longitude,
   input  logic [SpdW-1:0]          req_speed,
   input  logic [CogW-1:0]          req_course,
   input  logic [TimeW-1:0]         req_time_ms,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [31:0]              csr_data,
   output logic                     rsp_strobe,
   output logic [IdW-1:0]           rsp_out_vessel_id,
   output logic signed [OLatW-1:0]  rsp_out_latitude,
   output logic signed [OLonW-1:0]  rsp_out_longitude,
   output logic signed [OSpdW-1:0]  rsp_out_speed,
   output logic [CogW-1:0]          rsp_out_course,
   output logic                     rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tti_control u_control (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .stat        (stat),
      .cmd         (cmd)
   );

   tti_datapath #(
      .TRACKS          (TRACKS),
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_decode_ok     (req_decode_ok),
      .req_vessel_id     (req_vessel_id),
      .req_latitude      (req_latitude),
      .req_longitude     (req_longitude),
      .req_speed         (req_speed),
      .req_course        (req_course),
      .req_time_ms       (req_time_ms),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_vessel_id (rsp_out_vessel_id),
      .rsp_out_latitude  (rsp_out_latitude),
      .rsp_out_longitude (rsp_out_longitude),
      .rsp_out_speed     (rsp_out_speed),
      .rsp_out_course    (rsp_out_course),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTHESIS
   // A result beat always follows a busy cycle.
   a_beat_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a busy cycle before it");

   // Result beats never come back to back.
   a_single_cycle_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats back to back");

   // After the last beat of a query the block is idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after last beat");
`endif

endmodule
